// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; take in with a bare-name include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define DCRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DCRC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dcrc_pkg.sv =====
// Types, selection tables and the byte update for the dual CRC block.
// No dependencies.
package dcrc_pkg;

    localparam int unsigned CRC_W = 32;
    localparam int unsigned FN_W  = 3;

    // Function numbers; anything at or above FN_COUNT is invalid
    localparam logic [FN_W-1:0] FN_SEL0  = 3'd0;
    localparam logic [FN_W-1:0] FN_SEL1  = 3'd1;
    localparam logic [FN_W-1:0] FN_SEL2  = 3'd2;
    localparam logic [FN_W-1:0] FN_SEL3  = 3'd3;
    localparam logic [FN_W-1:0] FN_SEL4  = 3'd4;
    localparam logic [FN_W-1:0] FN_COUNT = 3'd5;

    localparam logic [CRC_W-1:0] POLY_IEEE   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] POLY_A001X2 = 32'hA001_A001;
    localparam logic [CRC_W-1:0] POLY_CCITT  = 32'h0000_8408;
    localparam logic [CRC_W-1:0] POLY_A001   = 32'h0000_A001;
    localparam logic [CRC_W-1:0] INIT_ONES32 = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] INIT_ONES16 = 32'h0000_FFFF;
    localparam logic [CRC_W-1:0] CRC_ZERO    = 32'h0000_0000;

    typedef struct packed {
        logic [CRC_W-1:0] crc_a;
        logic [CRC_W-1:0] crc_b;
        logic             in_msg;
        logic [CRC_W-1:0] checksum_a;
        logic [CRC_W-1:0] checksum_b;
        logic             valid_res;
    } step_out_t;

    function automatic logic [CRC_W-1:0] poly_a(input logic [FN_W-1:0] fn);
        logic [CRC_W-1:0] p;
        case (fn)
            FN_SEL0: p = POLY_IEEE;
            FN_SEL1: p = POLY_A001X2;
            FN_SEL2: p = POLY_CCITT;
            FN_SEL3: p = CRC_ZERO;
            FN_SEL4: p = POLY_A001X2;
            default: p = CRC_ZERO;
        endcase
        return p;
    endfunction

    function automatic logic [CRC_W-1:0] init_a(input logic [FN_W-1:0] fn);
        logic [CRC_W-1:0] v;
        case (fn)
            FN_SEL0: v = INIT_ONES32;
            FN_SEL1: v = CRC_ZERO;
            FN_SEL2: v = INIT_ONES16;
            FN_SEL3: v = INIT_ONES32;
            FN_SEL4: v = CRC_ZERO;
            default: v = CRC_ZERO;
        endcase
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] poly_b(input logic [FN_W-1:0] fn);
        logic [CRC_W-1:0] p;
        case (fn)
            FN_SEL0: p = POLY_A001X2;
            FN_SEL1: p = POLY_CCITT;
            FN_SEL2: p = POLY_IEEE;
            FN_SEL3: p = POLY_IEEE;
            FN_SEL4: p = POLY_A001;
            default: p = CRC_ZERO;
        endcase
        return p;
    endfunction

    function automatic logic [CRC_W-1:0] init_b(input logic [FN_W-1:0] fn);
        logic [CRC_W-1:0] v;
        case (fn)
            FN_SEL0: v = CRC_ZERO;
            FN_SEL1: v = INIT_ONES16;
            FN_SEL2: v = INIT_ONES32;
            FN_SEL3: v = INIT_ONES32;
            FN_SEL4: v = CRC_ZERO;
            default: v = CRC_ZERO;
        endcase
        return v;
    endfunction

    // Reflected byte update: xor into the low byte, then eight shift-right steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       data,
                                                  input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-8){1'b0}}, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ({1'b0, c[CRC_W-1:1]} ^ poly) : {1'b0, c[CRC_W-1:1]};
        end
        return c;
    endfunction

endpackage

// ===== src/dcrc_if.sv =====
// Channel interfaces for the dual CRC block: config write, byte input, result.
// Depends on dcrc_pkg for widths.
interface dcrc_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [dcrc_pkg::FN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface dcrc_out_if;
    logic                       valid;
    logic                       ready;
    logic [dcrc_pkg::CRC_W-1:0] checksum_a;
    logic [dcrc_pkg::CRC_W-1:0] checksum_b;
    logic                       valid_res;

    modport source (output valid, output checksum_a, output checksum_b,
                    output valid_res, input ready);
    modport sink   (input valid, input checksum_a, input checksum_b,
                    input valid_res, output ready);
endinterface

// ===== src/dcrc_step.sv =====
// Per-beat CRC step: message-start load, dual byte update and result select.
// Depends on dcrc_pkg.
module dcrc_step (
    input  logic [dcrc_pkg::FN_W-1:0]  fn,
    input  logic [dcrc_pkg::CRC_W-1:0] crc_a,
    input  logic [dcrc_pkg::CRC_W-1:0] crc_b,
    input  logic                       in_msg,
    input  logic [7:0]                 data_byte,
    input  logic                       has_byte,
    input  logic                       last,
    output dcrc_pkg::step_out_t        res
);
    import dcrc_pkg::*;

    logic             fn_ok;
    logic             upd;
    logic [CRC_W-1:0] base_a;
    logic [CRC_W-1:0] base_b;
    logic [CRC_W-1:0] new_a;
    logic [CRC_W-1:0] new_b;

    assign fn_ok  = (fn < FN_COUNT);
    assign upd    = has_byte && fn_ok;
    // Load init values at message start; invalid functions load zero
    assign base_a = in_msg ? crc_a : init_a(fn);
    assign base_b = in_msg ? crc_b : init_b(fn);
    assign new_a  = upd ? crc_byte(base_a, data_byte, poly_a(fn)) : base_a;
    assign new_b  = upd ? crc_byte(base_b, data_byte, poly_b(fn)) : base_b;

    always_comb
    begin
        res.crc_a      = new_a;
        res.crc_b      = new_b;
        res.in_msg     = !last;
        res.checksum_a = fn_ok ? new_a : CRC_ZERO;
        res.checksum_b = fn_ok ? new_b : CRC_ZERO;
        res.valid_res  = fn_ok;
    end
endmodule

// ===== src/dual_crc32_selectable.sv =====
// Top level of the dual selectable CRC-32 block.
// Depends on dcrc_pkg, dcrc_if.sv and dcrc_step.
//
//   channel | dir | fields                             | beat
//   cfg     | in  | data (function number, 3 bits)     | valid && ready
//   din     | in  | data_byte, has_byte, last          | valid && ready
//   dout    | out | checksum_a, checksum_b, valid_res  | valid && ready
//
// One byte per cycle sustained unless a last beat waits on a stalled result.
// The input register feeds the CRC step; the CRC and result registers close it.
// cfg is always ready. rst_n clears control, the CRC state and the function number.
// A stalled result holds the input register only when it holds a last beat.
module dual_crc32_selectable (
    input  logic clk,
    input  logic rst_n,
    dcrc_cfg_if.sink  cfg,
    dcrc_in_if.sink   din,
    dcrc_out_if.source dout
);
    import dcrc_pkg::*;

    logic [FN_W-1:0]  fn_reg;
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_has_reg;
    logic             s1_last_reg;
    logic [CRC_W-1:0] crc_a_reg;
    logic [CRC_W-1:0] crc_b_reg;
    logic             in_msg_reg;
    logic             out_valid_reg;
    logic [CRC_W-1:0] out_a_reg;
    logic [CRC_W-1:0] out_b_reg;
    logic             out_res_reg;

    logic      out_free;
    logic      s1_fire;
    logic      in_fire;
    step_out_t step;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fn_reg <= FN_SEL0;
        else if (cfg.valid)
            fn_reg <= cfg.data;
    end

    assign out_free = !out_valid_reg || dout.ready;
    // Non-last beats never touch the result register, so they never wait on it
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign din.ready = !s1_valid_reg || s1_fire;
    assign in_fire  = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (din.ready)
            s1_valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= din.data_byte;
            s1_has_reg  <= din.has_byte;
            s1_last_reg <= din.last;
        end
    end

    dcrc_step u_step (
        .fn        (fn_reg),
        .crc_a     (crc_a_reg),
        .crc_b     (crc_b_reg),
        .in_msg    (in_msg_reg),
        .data_byte (s1_byte_reg),
        .has_byte  (s1_has_reg),
        .last      (s1_last_reg),
        .res       (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_a_reg  <= CRC_ZERO;
            crc_b_reg  <= CRC_ZERO;
            in_msg_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            crc_a_reg  <= step.crc_a;
            crc_b_reg  <= step.crc_b;
            in_msg_reg <= step.in_msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_a_reg   <= step.checksum_a;
            out_b_reg   <= step.checksum_b;
            out_res_reg <= step.valid_res;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.checksum_a = out_a_reg;
    assign dout.checksum_b = out_b_reg;
    assign dout.valid_res  = out_res_reg;
endmodule

// ===== src/dcrc_checker.sv =====
// Port-level checks for dual_crc32_selectable, attached by bind.
// Depends on assert_macros.svh and dcrc_pkg.
`include "assert_macros.svh"

module dcrc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_ready,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [dcrc_pkg::CRC_W-1:0] checksum_a,
    input logic [dcrc_pkg::CRC_W-1:0] checksum_b,
    input logic                       valid_res
);
    import dcrc_pkg::*;

    // Hold a stalled result
    `DCRC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(checksum_a) && $stable(checksum_b) && $stable(valid_res), "stalled result changed")

    // An invalid function reports zero checksums
    `DCRC_ASSERT(a_invalid_zero, clk, rst_n, out_valid && !valid_res |-> checksum_a == CRC_ZERO && checksum_b == CRC_ZERO, "invalid function with nonzero checksum")

    // Input is never blocked while no result is pending
    `DCRC_ASSERT(a_in_ready, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")

    // Config always taken; no result during reset
    `DCRC_ASSERT_RST(a_cfg_ready, clk, rst_n |-> cfg_ready, "config write refused")
    `DCRC_ASSERT_RST(a_rst_quiet, clk, !rst_n |-> !out_valid, "result valid during reset")
endmodule

bind dual_crc32_selectable dcrc_checker u_dcrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg.ready),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .checksum_a (dout.checksum_a),
    .checksum_b (dout.checksum_b),
    .valid_res  (dout.valid_res)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for dual_crc32_selectable: a running dual-CRC predictor
// checks every checksum beat. Random flow control runs on the input and result channels.
// Depends on dcrc_pkg, the channel interfaces in dcrc_if.sv and the block itself.

typedef struct {
    logic [dcrc_pkg::CRC_W-1:0] sum_a;
    logic [dcrc_pkg::CRC_W-1:0] sum_b;
    logic                       ok;
} crc_sum_t;

class dual_crc_tracker;
    logic [dcrc_pkg::FN_W-1:0]  fn_sel;
    logic [dcrc_pkg::CRC_W-1:0] crc_a;
    logic [dcrc_pkg::CRC_W-1:0] crc_b;
    logic                       in_msg;
    crc_sum_t                   sums_due[$];
    int                         errors;
    int                         items_taken;
    int                         sums_seen;
    int                         bad_fn_sums;

    function new();
        fn_sel      = dcrc_pkg::FN_SEL0;
        crc_a       = '0;
        crc_b       = '0;
        in_msg      = 1'b0;
        errors      = 0;
        items_taken = 0;
        sums_seen   = 0;
        bad_fn_sums = 0;
    endfunction

    function void set_fn(logic [dcrc_pkg::FN_W-1:0] f);
        fn_sel = f;
    endfunction

    // Polynomial and seed per function number; side 0 is CRC A, side 1 is CRC B
    function logic [dcrc_pkg::CRC_W-1:0] poly_for(logic [dcrc_pkg::FN_W-1:0] f, bit side);
        logic [31:0] pa;
        logic [31:0] pb;
        case (f)
            dcrc_pkg::FN_SEL0: begin pa = 32'hEDB8_8320; pb = 32'hA001_A001; end
            dcrc_pkg::FN_SEL1: begin pa = 32'hA001_A001; pb = 32'h0000_8408; end
            dcrc_pkg::FN_SEL2: begin pa = 32'h0000_8408; pb = 32'hEDB8_8320; end
            dcrc_pkg::FN_SEL3: begin pa = 32'h0000_0000; pb = 32'hEDB8_8320; end
            dcrc_pkg::FN_SEL4: begin pa = 32'hA001_A001; pb = 32'h0000_A001; end
            default:           begin pa = 32'h0;         pb = 32'h0;         end
        endcase
        return side ? pb : pa;
    endfunction

    function logic [dcrc_pkg::CRC_W-1:0] seed_for(logic [dcrc_pkg::FN_W-1:0] f, bit side);
        logic [31:0] sa;
        logic [31:0] sb;
        case (f)
            dcrc_pkg::FN_SEL0: begin sa = 32'hFFFF_FFFF; sb = 32'h0000_0000; end
            dcrc_pkg::FN_SEL1: begin sa = 32'h0000_0000; sb = 32'h0000_FFFF; end
            dcrc_pkg::FN_SEL2: begin sa = 32'h0000_FFFF; sb = 32'hFFFF_FFFF; end
            dcrc_pkg::FN_SEL3: begin sa = 32'hFFFF_FFFF; sb = 32'hFFFF_FFFF; end
            dcrc_pkg::FN_SEL4: begin sa = 32'h0000_0000; sb = 32'h0000_0000; end
            default:           begin sa = 32'h0;         sb = 32'h0;         end
        endcase
        return side ? sb : sa;
    endfunction

    // Reflected update: fold the byte into the low bits, then eight LSB-first shifts
    function logic [dcrc_pkg::CRC_W-1:0] fold_byte(logic [31:0] c, logic [7:0] b,
                                                   logic [31:0] p);
        logic [31:0] r;
        logic        lsb;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            lsb = r[0];
            r   = r >> 1;
            if (lsb)
                r = r ^ p;
        end
        return r;
    endfunction

    function void take_item(logic [7:0] b, logic hb, logic lst);
        crc_sum_t s;
        logic     fn_ok;
        fn_ok = (fn_sel < dcrc_pkg::FN_COUNT);
        items_taken++;
        // Seeds load at message start only; polynomials follow the current setting
        if (!in_msg) begin
            crc_a  = seed_for(fn_sel, 1'b0);
            crc_b  = seed_for(fn_sel, 1'b1);
            in_msg = 1'b1;
        end
        if (hb && fn_ok) begin
            crc_a = fold_byte(crc_a, b, poly_for(fn_sel, 1'b0));
            crc_b = fold_byte(crc_b, b, poly_for(fn_sel, 1'b1));
        end
        if (lst) begin
            in_msg = 1'b0;
            s.sum_a = fn_ok ? crc_a : '0;
            s.sum_b = fn_ok ? crc_b : '0;
            s.ok    = fn_ok;
            sums_due.push_back(s);
        end
    endfunction

    function void match_result(logic [31:0] a, logic [31:0] b, logic v);
        crc_sum_t s;
        if (sums_due.size() == 0) begin
            $display("%0t: unexpected result beat a=%h b=%h valid_res=%b", $time, a, b, v);
            errors++;
            return;
        end
        s = sums_due.pop_front();
        sums_seen++;
        if (!s.ok)
            bad_fn_sums++;
        if (a !== s.sum_a) begin
            $display("%0t: checksum_a expected %h actual %h", $time, s.sum_a, a);
            errors++;
        end
        if (b !== s.sum_b) begin
            $display("%0t: checksum_b expected %h actual %h", $time, s.sum_b, b);
            errors++;
        end
        if (v !== s.ok) begin
            $display("%0t: valid_res expected %b actual %b", $time, s.ok, v);
            errors++;
        end
    endfunction

    function int pending();
        return sums_due.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dcrc_pkg::*;

    localparam logic [FN_W-1:0] FN_BAD_MID = 3'd6;
    localparam logic [FN_W-1:0] FN_BAD_TOP = 3'd7;
    localparam int PHASE_ITEMS = 330;
    localparam int SEG_ITEMS   = 40;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    dcrc_cfg_if cfg_ch();
    dcrc_in_if  in_ch();
    dcrc_out_if out_ch();

    dual_crc_tracker crc_track;

    dual_crc32_selectable DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .din   (in_ch),
        .dout  (out_ch)
    );

    always #6 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // Result side: stall at random, check each beat at the rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            crc_track.match_result(out_ch.checksum_a, out_ch.checksum_b, out_ch.valid_res);
    end

    // Caller stands at a falling edge; returns at the falling edge after the beat
    task automatic push_item(input logic [7:0] b, input logic hb, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte  <= hb;
        in_ch.last      <= lst;
        do
            @(posedge clk);
        while (!in_ch.ready);
        crc_track.take_item(b, hb, lst);
        @(negedge clk);
    endtask

    // Let the block go quiet: wait for every result and for trailing beats
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (crc_track.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_function(input logic [FN_W-1:0] f);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= f;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        crc_track.set_fn(f);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_message(input int len, input bit close);
        logic hb;
        for (int i = 0; i < len; i++)
        begin
            hb = ($urandom_range(9) != 0);
            push_item(8'($urandom_range(255)), hb, close && (i == len - 1));
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle);
        int               start;
        int               seg_start;
        int               len;
        int               r;
        logic [FN_W-1:0]  f;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        start = crc_track.items_taken;
        while (crc_track.items_taken - start < PHASE_ITEMS)
        begin
            drain_block();
            r = $urandom_range(9);
            f = (r < 8) ? FN_W'(r % 5) : FN_W'($urandom_range(7, 5));
            set_function(f);
            seg_start = crc_track.items_taken;
            while (crc_track.items_taken - seg_start < SEG_ITEMS)
            begin
                if ($urandom_range(11) == 0)
                    push_item(8'($urandom_range(255)), 1'b0, 1'b1);
                else
                begin
                    len = ($urandom_range(15) == 0) ? $urandom_range(32, 16)
                                                    : $urandom_range(8, 1);
                    send_message(len, 1'b1);
                end
            end
            // Leave a message open now and then so the next setting lands mid-message
            if ($urandom_range(2) == 0)
                send_message($urandom_range(4, 1), 1'b0);
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte  = 1'b0;
        in_ch.last      = 1'b0;
        crc_track       = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Function number straight out of reset: empty message, then two bytes
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        for (int f = FN_SEL1; f <= FN_SEL4; f++)
        begin
            drain_block();
            set_function(FN_W'(f));
            push_item(8'h80, 1'b1, 1'b0);
            push_item(8'h01, 1'b1, 1'b1);
        end
        drain_block();
        set_function(FN_BAD_TOP);
        push_item(8'hA5, 1'b1, 1'b1);
        drain_block();
        set_function(FN_COUNT);
        push_item(8'h00, 1'b0, 1'b1);
        // Switch polynomials mid-message, with a byteless beat inside
        drain_block();
        set_function(FN_SEL2);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h7E, 1'b0, 1'b0);
        drain_block();
        set_function(FN_SEL3);
        push_item(8'h3C, 1'b1, 1'b1);
        // Valid to invalid mid-message, then invalid-seeded message finished valid
        drain_block();
        set_function(FN_SEL1);
        push_item(8'h11, 1'b1, 1'b0);
        drain_block();
        set_function(FN_BAD_MID);
        push_item(8'h22, 1'b1, 1'b1);
        drain_block();
        push_item(8'h33, 1'b1, 1'b0);
        drain_block();
        set_function(FN_SEL0);
        push_item(8'hC3, 1'b1, 1'b1);

        run_phase(9, 72);
        run_phase(72, 9);
        run_phase(0, 0);
        drain_block();
        repeat (10) @(posedge clk);

        $display("Covered %0d input beats and %0d checksum results (%0d with invalid function).",
                 crc_track.items_taken, crc_track.sums_seen, crc_track.bad_fn_sums);
        $display("Function numbers 0 to 7 written between messages and mid-message, three stall mixes.");
        if (crc_track.errors == 0 && crc_track.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
